/* rtl/sorted_timer_expiry_queue_core_assert.svh */
// Assertion macros used by the timer queue core.
`ifndef SORTED_TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stq_pkg.sv */
// Shared constants, types and codes of the sorted timer queue.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

    localparam int ENTRIES   = 64;
    localparam int TIME_BITS = 32;
    localparam int ID_BITS   = 6;
    localparam int ID_SPACE  = 1 << ID_BITS;
    localparam int ORD_AW    = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ID_BITS-1:0]   t_id;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_ADJUST,
        KIND_DELETE,
        KIND_TICK
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_PRESENT,
        ST_ABSENT,
        ST_EXPIRED,
        ST_NONE
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  entry_id;
        logic [31:0] expire_time;
        logic [31:0] current_time;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [5:0]  expired_id;
        logic [31:0] expired_at;
        logic        last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_DEL_FIND,
        S_SHIFT,
        S_INS_INIT,
        S_INS_SCAN,
        S_INS_LAST,
        S_TK_RD,
        S_TK_ID,
        S_TK_CMP,
        S_TK_DEC,
        S_TK_END
    } t_state;

endpackage
`default_nettype wire

/* rtl/stq_req_if.sv */
// Request channel of the timer queue: valid, ready and one request.
`timescale 1ns / 1ps
`default_nettype none
interface stq_req_if;
    import stq_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/stq_rsp_if.sv */
// Result channel of the timer queue: valid, ready and one result.
`timescale 1ns / 1ps
`default_nettype none
interface stq_rsp_if;
    import stq_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/stq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/sorted_timer_expiry_queue_core.sv */
// Top level of the sorted timer expiry queue.
//
// Channel   Dir  Modport  Carries
// i_req     in   sink     kind, entry_id, expire_time, current_time
// o_rsp     out  source   status, expired_id, expired_at, last
//
// Add: a backward insert scan of the order RAM moves later ids up one slot.
// Delete: a find pass up to the hit, then a left shift of the rest.
// Adjust: delete plus add. Tick: order read, id read, compare and pop per expired
// timer, then a compaction pass over the remaining entries.
// Reset is synchronous, active low; both RAMs need no clearing, the valid bits do.
// A stalled result holds the engine only where it must hand over another result.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_expiry_queue_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stq_req_if.sink   i_req,
    stq_rsp_if.source o_rsp
);
    import stq_pkg::*;

    `include "sorted_timer_expiry_queue_core_assert.svh"

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    // control
    t_cnt                r_count, n_count;       // timers in the queue
    logic [ID_SPACE-1:0] r_valid, n_valid;       // one bit per timer id
    logic                r_out_valid, n_out_valid;
    logic                r_rd_more, n_rd_more;   // more order reads to issue
    logic                r_b_v, n_b_v;           // order read data valid
    logic                r_c_v, n_c_v;           // time read data valid
    logic                r_have_pend, n_have_pend;

    // payload
    t_kind   r_kind, n_kind;
    t_id     r_id, n_id;
    t_time   r_etime, n_etime;
    t_time   r_ctime, n_ctime;
    t_status r_status, n_status;
    t_cnt    r_ri, n_ri;          // order read index / tick position
    t_cnt    r_b_idx, n_b_idx;    // index of the order word now on the RAM output
    t_cnt    r_c_idx, n_c_idx;    // index of the entry whose time is now on the output
    t_id     r_c_id, n_c_id;
    t_cnt    r_off, n_off;        // left shift distance
    t_id     r_cur_id, n_cur_id;
    t_time   r_cur_time, n_cur_time;
    t_id     r_pend_id, n_pend_id;
    t_time   r_pend_time, n_pend_time;
    t_rsp    r_out, n_out;

    // RAM ports
    logic              ord_we;
    logic [ORD_AW-1:0] ord_waddr;
    t_id               ord_wdata;
    logic [ORD_AW-1:0] ord_raddr;
    t_id               ord_rdata;

    logic   tim_we;
    t_id    tim_waddr;
    t_time  tim_wdata;
    t_id    tim_raddr;
    t_time  tim_rdata;

    // Ids in expiry order, slots 0 .. count-1 meaningful.
    stq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (ENTRIES)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // Expiry time per timer id.
    stq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (ID_SPACE)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (tim_we),
        .i_waddr (tim_waddr),
        .i_wdata (tim_wdata),
        .i_raddr (tim_raddr),
        .o_rdata (tim_rdata)
    );

    // ---------------------------------------------------------------
    // Shared decode
    // ---------------------------------------------------------------
    logic  w_acc;
    logic  w_out_free;
    logic  w_full;
    logic  w_req_valid_id;
    logic  w_ins_gt;       // stored time later than the new one: keep shifting
    logic  w_tk_due;
    logic  w_del_hit;
    logic  w_shift_done;
    logic  w_ri_lt;
    t_cnt  w_ri_inc;
    t_cnt  w_b_inc;
    t_cnt  w_shift_dst;
    t_cnt  w_ins_dst;

    assign i_req.ready    = (r_state == S_IDLE);
    assign w_acc          = i_req.valid && (r_state == S_IDLE);
    assign w_out_free     = !r_out_valid || o_rsp.ready;
    assign w_full         = (r_count >= CNT_W'(ENTRIES));
    assign w_req_valid_id = r_valid[i_req.payload.entry_id];
    assign w_ins_gt       = (tim_rdata > r_etime);
    assign w_tk_due       = (tim_rdata <= r_ctime);
    assign w_del_hit      = r_b_v && (ord_rdata == r_id);
    assign w_shift_done   = !r_rd_more && !r_b_v;
    assign w_ri_lt        = (r_ri < r_count);
    assign w_ri_inc       = r_ri + CNT_W'(1);
    assign w_b_inc        = r_b_idx + CNT_W'(1);
    assign w_shift_dst    = r_b_idx - r_off;
    assign w_ins_dst      = r_c_idx + CNT_W'(1);

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.payload.kind)
                        KIND_ADD: begin
                            n_state = (w_req_valid_id || w_full) ? S_RESP : S_INS_INIT;
                        end
                        KIND_ADJUST, KIND_DELETE: begin
                            n_state = w_req_valid_id ? S_DEL_FIND : S_RESP;
                        end
                        KIND_TICK: n_state = S_TK_RD;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL_FIND: begin
                if (w_del_hit) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_shift_done) begin
                    case (r_kind)
                        KIND_ADJUST: n_state = S_INS_INIT;
                        KIND_DELETE: n_state = S_RESP;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_INIT: begin
                n_state = (r_count == '0) ? S_RESP : S_INS_SCAN;
            end
            S_INS_SCAN: begin
                if (r_c_v) begin
                    if (!w_ins_gt) begin
                        n_state = S_RESP;
                    end else if (r_c_idx == '0) begin
                        n_state = S_INS_LAST;
                    end
                end
            end
            S_INS_LAST: n_state = S_RESP;
            S_TK_RD:    n_state = w_ri_lt ? S_TK_ID : S_TK_END;
            S_TK_ID:    n_state = S_TK_CMP;
            S_TK_CMP:   n_state = w_tk_due ? S_TK_DEC : S_TK_END;
            S_TK_DEC: begin
                if (!r_have_pend || w_out_free) begin
                    n_state = S_TK_RD;
                end
            end
            S_TK_END: begin
                if (w_out_free) begin
                    n_state = S_SHIFT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and RAM control
    // ---------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_rd_more   = r_rd_more;
        n_b_v       = r_b_v;
        n_c_v       = r_c_v;
        n_have_pend = r_have_pend;
        n_kind      = r_kind;
        n_id        = r_id;
        n_etime     = r_etime;
        n_ctime     = r_ctime;
        n_status    = r_status;
        n_ri        = r_ri;
        n_b_idx     = r_b_idx;
        n_c_idx     = r_c_idx;
        n_c_id      = r_c_id;
        n_off       = r_off;
        n_cur_id    = r_cur_id;
        n_cur_time  = r_cur_time;
        n_pend_id   = r_pend_id;
        n_pend_time = r_pend_time;
        n_out       = r_out;

        ord_we    = 1'b0;
        ord_waddr = '0;
        ord_wdata = r_id;
        ord_raddr = r_ri[ORD_AW-1:0];
        tim_we    = 1'b0;
        tim_waddr = r_id;
        tim_wdata = r_etime;
        tim_raddr = ord_rdata;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_kind      = i_req.payload.kind;
                    n_id        = i_req.payload.entry_id;
                    n_etime     = t_time'(i_req.payload.expire_time);
                    n_ctime     = t_time'(i_req.payload.current_time);
                    n_ri        = '0;
                    n_rd_more   = (r_count != '0);
                    n_b_v       = 1'b0;
                    n_have_pend = 1'b0;
                    case (i_req.payload.kind)
                        KIND_ADD: begin
                            n_status = w_req_valid_id ? ST_PRESENT : ST_FULL;
                        end
                        KIND_ADJUST, KIND_DELETE: n_status = ST_ABSENT;
                        default:                  n_status = ST_OK;
                    endcase
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_status;
                    n_out.expired_id = '0;
                    n_out.expired_at = '0;
                    n_out.last       = 1'b1;
                end
            end
            S_DEL_FIND, S_SHIFT: begin
                // shift writes trail the reads, so no address is read after its write
                if ((r_state == S_SHIFT) && r_b_v) begin
                    ord_we    = 1'b1;
                    ord_waddr = w_shift_dst[ORD_AW-1:0];
                    ord_wdata = ord_rdata;
                end
                if ((r_state == S_DEL_FIND) && w_del_hit) begin
                    n_ri      = w_b_inc;
                    n_off     = CNT_W'(1);
                    n_rd_more = (w_b_inc < r_count);
                    n_b_v     = 1'b0;
                end else if (r_rd_more) begin
                    n_b_v     = 1'b1;
                    n_b_idx   = r_ri;
                    n_ri      = w_ri_inc;
                    n_rd_more = (w_ri_inc < r_count);
                end else begin
                    n_b_v = 1'b0;
                end
                if ((r_state == S_SHIFT) && w_shift_done) begin
                    n_count = r_count - r_off;
                    if (r_kind != KIND_TICK) begin
                        n_valid[r_id] = 1'b0;
                    end
                    n_status = ST_OK;
                end
            end
            S_INS_INIT: begin
                tim_we = 1'b1;
                n_b_v  = 1'b0;
                n_c_v  = 1'b0;
                if (r_count == '0) begin
                    ord_we        = 1'b1;
                    ord_waddr     = '0;
                    n_count       = r_count + CNT_W'(1);
                    n_valid[r_id] = 1'b1;
                    n_status      = ST_OK;
                end else begin
                    n_ri      = r_count - CNT_W'(1);
                    n_rd_more = 1'b1;
                end
            end
            S_INS_SCAN: begin
                // tail-first walk: move later entries up one slot until the
                // first entry at or before the new time, then drop the id in
                if (r_c_v) begin
                    ord_we    = 1'b1;
                    ord_waddr = w_ins_dst[ORD_AW-1:0];
                    if (w_ins_gt) begin
                        ord_wdata = r_c_id;
                    end else begin
                        ord_wdata     = r_id;
                        n_count       = r_count + CNT_W'(1);
                        n_valid[r_id] = 1'b1;
                        n_status      = ST_OK;
                    end
                end
                if (r_b_v) begin
                    n_c_v   = 1'b1;
                    n_c_idx = r_b_idx;
                    n_c_id  = ord_rdata;
                end else begin
                    n_c_v = 1'b0;
                end
                if (r_rd_more) begin
                    n_b_v     = 1'b1;
                    n_b_idx   = r_ri;
                    n_rd_more = (r_ri != '0);
                    n_ri      = r_ri - CNT_W'(1);
                end else begin
                    n_b_v = 1'b0;
                end
            end
            S_INS_LAST: begin
                // every stored timer is later: new id goes to the head
                ord_we        = 1'b1;
                ord_waddr     = '0;
                n_count       = r_count + CNT_W'(1);
                n_valid[r_id] = 1'b1;
                n_status      = ST_OK;
            end
            S_TK_RD: begin
                ord_raddr = r_ri[ORD_AW-1:0];
            end
            S_TK_ID: begin
                n_cur_id = ord_rdata;
            end
            S_TK_CMP: begin
                n_cur_time = tim_rdata;
            end
            S_TK_DEC: begin
                // one result is held back so the final one can carry last
                if (!r_have_pend || w_out_free) begin
                    if (r_have_pend) begin
                        n_out_valid      = 1'b1;
                        n_out.status     = ST_EXPIRED;
                        n_out.expired_id = r_pend_id;
                        n_out.expired_at = 32'(r_pend_time);
                        n_out.last       = 1'b0;
                    end
                    n_pend_id         = r_cur_id;
                    n_pend_time       = r_cur_time;
                    n_have_pend       = 1'b1;
                    n_valid[r_cur_id] = 1'b0;
                    n_ri              = w_ri_inc;
                end
            end
            S_TK_END: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.last  = 1'b1;
                    if (r_have_pend) begin
                        n_out.status     = ST_EXPIRED;
                        n_out.expired_id = r_pend_id;
                        n_out.expired_at = 32'(r_pend_time);
                    end else begin
                        n_out.status     = ST_NONE;
                        n_out.expired_id = '0;
                        n_out.expired_at = '0;
                    end
                    // compact survivors down by the number expired
                    n_off     = r_ri;
                    n_rd_more = w_ri_lt;
                    n_b_v     = 1'b0;
                end
            end
            default: begin
                n_b_v = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_rd_more   <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_rd_more   <= n_rd_more;
            r_b_v       <= n_b_v;
            r_c_v       <= n_c_v;
            r_have_pend <= n_have_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_id        <= n_id;
        r_etime     <= n_etime;
        r_ctime     <= n_ctime;
        r_status    <= n_status;
        r_ri        <= n_ri;
        r_b_idx     <= n_b_idx;
        r_c_idx     <= n_c_idx;
        r_c_id      <= n_c_id;
        r_off       <= n_off;
        r_cur_id    <= n_cur_id;
        r_cur_time  <= n_cur_time;
        r_pend_id   <= n_pend_id;
        r_pend_time <= n_pend_time;
        r_out       <= n_out;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `STQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(ENTRIES), "queue count above capacity")
    `STQ_ASSERT_IMPLY(a_valid_matches_count, i_clk, i_rst_n, r_state == S_IDLE,
        $countones(r_valid) == int'(r_count), "valid bits disagree with queue count")
    `STQ_ASSERT_IMPLY(a_insert_has_room, i_clk, i_rst_n, r_state == S_INS_INIT,
        r_count < CNT_W'(ENTRIES), "insert started on a full queue")
    `STQ_ASSERT_NEXT(a_request_starts_work, i_clk, i_rst_n, i_req.valid && i_req.ready,
        r_state != S_IDLE, "accepted request left engine idle")

endmodule
`default_nettype wire

/* tb/sv/sorted_timer_expiry_queue_core_tb.sv */
// Self-checking bench for the sorted timer expiry queue: directed, fill-to-full and random requests.
`timescale 1ns / 1ps
module sorted_timer_expiry_queue_core_tb;
    import stq_pkg::*;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    stq_req_if req_if ();
    stq_rsp_if rsp_if ();

    sorted_timer_expiry_queue_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Requests waiting to be driven, and the results the shadow queue says must come back,
    // oldest first.
    t_req queued_requests[$];
    t_rsp timer_outcomes[$];

    // Shadow of the timer queue: ids in expiry order, plus per-id time and live flag.
    t_id   shadow_order[$];
    t_time shadow_time[ID_SPACE];
    bit    shadow_live[ID_SPACE];

    int unsigned fault_count = 0;

    // Handshake pacing: each side draws a wait per request or result; a burst flag
    // gives stretches with no idling at all.
    bit          req_burst = 1'b0;
    bit          rsp_burst = 1'b0;
    int unsigned req_gap;
    int unsigned req_draw;
    int unsigned rsp_stall;
    int unsigned rsp_draw;

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic t_req make_req(input t_kind k, input t_id id, input t_time et,
                                      input t_time ct);
        t_req r;
        r.kind         = k;
        r.entry_id     = id;
        r.expire_time  = et;
        r.current_time = ct;
        return r;
    endfunction

    // Insert after every stored timer whose time is at or below the new one, so ties
    // keep the order of the most recent add or adjust.
    task automatic place_timer(input t_id id, input t_time t);
        int pos;
        pos = 0;
        while (pos < shadow_order.size() && shadow_time[shadow_order[pos]] <= t)
            pos++;
        shadow_order.insert(pos, id);
        shadow_time[id] = t;
        shadow_live[id] = 1'b1;
    endtask

    task automatic drop_timer(input t_id id);
        int pos;
        pos = 0;
        while (pos < shadow_order.size() && shadow_order[pos] != id)
            pos++;
        if (pos < shadow_order.size())
            shadow_order.delete(pos);
        shadow_live[id] = 1'b0;
    endtask

    // Works out the results of one accepted request and updates the shadow queue.
    task automatic apply_timer_request(input t_req r);
        t_rsp o;
        t_id  id;
        o      = '0;
        o.last = 1'b1;
        id     = r.entry_id;
        case (r.kind)
            KIND_ADD: begin
                // A present id is reported before a full queue is.
                if (shadow_live[id])
                    o.status = ST_PRESENT;
                else if (shadow_order.size() >= ENTRIES)
                    o.status = ST_FULL;
                else begin
                    place_timer(id, r.expire_time);
                    o.status = ST_OK;
                end
                timer_outcomes.push_back(o);
            end
            KIND_ADJUST: begin
                if (!shadow_live[id])
                    o.status = ST_ABSENT;
                else begin
                    drop_timer(id);
                    place_timer(id, r.expire_time);
                    o.status = ST_OK;
                end
                timer_outcomes.push_back(o);
            end
            KIND_DELETE: begin
                if (!shadow_live[id])
                    o.status = ST_ABSENT;
                else begin
                    drop_timer(id);
                    o.status = ST_OK;
                end
                timer_outcomes.push_back(o);
            end
            default: begin
                // Tick: pop every due timer from the head; nothing due gives one result.
                if (shadow_order.size() == 0 ||
                    shadow_time[shadow_order[0]] > r.current_time) begin
                    o.status = ST_NONE;
                    timer_outcomes.push_back(o);
                end else begin
                    while (shadow_order.size() != 0 &&
                           shadow_time[shadow_order[0]] <= r.current_time) begin
                        id               = shadow_order.pop_front();
                        shadow_live[id]  = 1'b0;
                        o.status         = ST_EXPIRED;
                        o.expired_id     = id;
                        o.expired_at     = shadow_time[id];
                        o.last           = (shadow_order.size() == 0) ||
                                           (shadow_time[shadow_order[0]] > r.current_time);
                        timer_outcomes.push_back(o);
                    end
                end
            end
        endcase
    endtask

    // Request driver: presents queued requests, one wait drawn after each accept.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_gap      <= draw_wait(req_burst);
        end else if (req_if.valid && req_if.ready) begin
            apply_timer_request(req_if.payload);
            if ($urandom_range(0, 31) == 0)
                req_burst = !req_burst;
            req_draw = draw_wait(req_burst);
            if (req_draw == 0 && queued_requests.size() != 0) begin
                // Back to back: valid stays high, only the payload moves on.
                req_if.payload <= queued_requests.pop_front();
            end else begin
                req_if.valid <= 1'b0;
                req_gap      <= req_draw;
            end
        end else if (!req_if.valid) begin
            if (req_gap != 0) begin
                req_gap <= req_gap - 1;
            end else if (queued_requests.size() != 0) begin
                req_if.valid   <= 1'b1;
                req_if.payload <= queued_requests.pop_front();
            end
        end
    end

    // Result monitor: the stall counts down only while a result is offered, so it
    // really holds the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= 0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            if (timer_outcomes.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result with none pending: status %0d id %0d at %0d last %0b",
                             rsp_if.payload.status, rsp_if.payload.expired_id,
                             rsp_if.payload.expired_at, rsp_if.payload.last);
            end else begin
                t_rsp want;
                want = timer_outcomes.pop_front();
                if (rsp_if.payload.status !== want.status ||
                    rsp_if.payload.expired_id !== want.expired_id ||
                    rsp_if.payload.expired_at !== want.expired_at ||
                    rsp_if.payload.last !== want.last) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: exp status %0d id %0d at %0d last %0b, got %0d %0d %0d %0b",
                                 want.status, want.expired_id, want.expired_at, want.last,
                                 rsp_if.payload.status, rsp_if.payload.expired_id,
                                 rsp_if.payload.expired_at, rsp_if.payload.last);
                end
            end
            if ($urandom_range(0, 31) == 0)
                rsp_burst = !rsp_burst;
            rsp_draw = draw_wait(rsp_burst);
            rsp_stall    <= rsp_draw;
            rsp_if.ready <= (rsp_draw == 0);
        end else if (!rsp_if.ready) begin
            if (rsp_stall == 0)
                rsp_if.ready <= 1'b1;
            else if (rsp_if.valid)
                rsp_stall <= rsp_stall - 1;
        end
    end

    // Stimulus and end of run
    initial begin
        t_id         perm[ID_SPACE];
        t_id         hot_ids[8];
        t_id         id;
        t_id         tmp;
        t_time       now_t;
        int unsigned sel;
        int          j;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;

        // Directed: empty queue corners, ties, moves both ways, field extremes.
        // Tick on an empty queue, delete and adjust of an absent id.
        queued_requests.push_back(make_req(KIND_TICK, 6'd0, 32'd0, 32'd0));
        queued_requests.push_back(make_req(KIND_DELETE, 6'd5, 32'd0, 32'd0));
        queued_requests.push_back(make_req(KIND_ADJUST, 6'd7, 32'd9, 32'd0));
        queued_requests.push_back(make_req(KIND_ADD, 6'd0, 32'd0, 32'hFFFF_FFFF));
        queued_requests.push_back(make_req(KIND_ADD, 6'd63, 32'hFFFF_FFFF, 32'd0));
        // Add of an id that is already queued.
        queued_requests.push_back(make_req(KIND_ADD, 6'd0, 32'd77, 32'd0));
        queued_requests.push_back(make_req(KIND_ADD, 6'd10, 32'd100, 32'd0));
        // Equal times: the newer one goes behind; adjust to the same time re-queues last.
        queued_requests.push_back(make_req(KIND_ADD, 6'd11, 32'd100, 32'd0));
        queued_requests.push_back(make_req(KIND_ADJUST, 6'd10, 32'd100, 32'd0));
        // Adjust earlier, then later.
        queued_requests.push_back(make_req(KIND_ADJUST, 6'd63, 32'd50, 32'd0));
        queued_requests.push_back(make_req(KIND_ADJUST, 6'd11, 32'd200, 32'd0));
        queued_requests.push_back(make_req(KIND_DELETE, 6'd0, 32'd0, 32'd0));
        // Nothing due, then two due at once, one exactly at the current time.
        queued_requests.push_back(make_req(KIND_TICK, 6'd0, 32'd0, 32'd49));
        queued_requests.push_back(make_req(KIND_TICK, 6'd0, 32'd0, 32'd100));
        queued_requests.push_back(make_req(KIND_ADD, 6'd42, 32'hAAAA_AAAA, 32'h5555_5555));
        queued_requests.push_back(make_req(KIND_ADD, 6'd21, 32'h5555_5555, 32'hAAAA_AAAA));
        queued_requests.push_back(make_req(KIND_TICK, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queued_requests.push_back(make_req(KIND_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF));
        queued_requests.push_back(make_req(KIND_DELETE, 6'd63, 32'd0, 32'd0));

        // Fill to capacity with every id in random order, many times clustered for ties.
        for (j = 0; j < ID_SPACE; j++)
            perm[j] = t_id'(j);
        for (j = ID_SPACE - 1; j > 0; j--) begin
            sel       = $urandom_range(0, j);
            tmp       = perm[j];
            perm[j]   = perm[sel];
            perm[sel] = tmp;
        end
        for (j = 0; j < ID_SPACE; j++)
            queued_requests.push_back(make_req(KIND_ADD, perm[j],
                ($urandom_range(0, 1) != 0) ? t_time'($urandom_range(1000, 1007)) : $urandom(),
                $urandom()));
        // Moves while full, delete and refill, add of a present id while full.
        for (j = 0; j < 3; j++)
            queued_requests.push_back(make_req(KIND_ADJUST, perm[$urandom_range(0, 63)],
                t_time'($urandom_range(995, 1010)), $urandom()));
        queued_requests.push_back(make_req(KIND_DELETE, perm[0], $urandom(), $urandom()));
        queued_requests.push_back(make_req(KIND_ADD, perm[0], 32'd1003, $urandom()));
        queued_requests.push_back(make_req(KIND_ADD, perm[5], $urandom(), $urandom()));
        // One tick drains all 64 timers.
        queued_requests.push_back(make_req(KIND_TICK, perm[9], $urandom(), 32'hFFFF_FFFF));

        // Random: a small set of hot ids so adds collide and adjusts/deletes mostly hit,
        // times following a slowly advancing clock, plus some noise.
        for (j = 0; j < 8; j++)
            hot_ids[j] = t_id'($urandom_range(0, 63));
        now_t = t_time'($urandom_range(0, 5000));
        for (j = 0; j < 110; j++) begin
            sel = $urandom_range(0, 99);
            id  = ($urandom_range(0, 3) == 0) ? t_id'($urandom_range(0, 63))
                                              : hot_ids[$urandom_range(0, 7)];
            if (sel < 8)
                queued_requests.push_back(make_req(t_kind'($urandom_range(0, 3)),
                    t_id'($urandom_range(0, 63)), $urandom(), $urandom()));
            else if (sel < 43)
                queued_requests.push_back(make_req(KIND_ADD, id,
                    now_t + t_time'($urandom_range(0, 40)), $urandom()));
            else if (sel < 60)
                queued_requests.push_back(make_req(KIND_ADJUST, id,
                    now_t + t_time'($urandom_range(0, 40)), $urandom()));
            else if (sel < 72)
                queued_requests.push_back(make_req(KIND_DELETE, id, $urandom(), $urandom()));
            else begin
                now_t = now_t + t_time'($urandom_range(0, 25));
                queued_requests.push_back(make_req(KIND_TICK, id, $urandom(), now_t));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every request sent, every result back, then a quiet window long
        // enough for a full tick plus compaction to show any stray result.
        while (queued_requests.size() != 0 || req_if.valid || timer_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        if (fault_count == 0 && timer_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #(64'd20_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
